// File: rtl/core/agcc_pkg.sv
package agcc_pkg;

  // Node indices are fixed at four bits by the command format.
  localparam int MAX_NODES = 16;
  localparam int IDX_W     = 4;
  localparam int CNT_W     = 5;
  localparam int CMD_W     = 2;

  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COUNT = 2'd2;

  typedef logic [MAX_NODES-1:0] node_mask_t;
  typedef logic [IDX_W-1:0]     node_idx_t;

  typedef struct packed {
    logic      wr_en;
    node_idx_t wr_src;
    node_idx_t wr_dst;
    logic      clear_vis;
    logic      set_root;
    node_idx_t root;
    logic      expand;
  } cell_ctrl_t;

endpackage

// File: rtl/core/agcc_cell.sv
module agcc_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  agcc_pkg::node_idx_t cell_idx,
  input  agcc_pkg::cell_ctrl_t ctrl,
  input  agcc_pkg::node_mask_t in_use,
  input  agcc_pkg::node_mask_t reach_in,
  input  agcc_pkg::node_mask_t acc_in,
  output agcc_pkg::node_mask_t acc_out,
  output agcc_pkg::node_mask_t row,
  output logic                vis
);

  agcc_pkg::node_mask_t row_r, row_nxt;
  logic                 vis_r, vis_nxt;

  always_comb begin
    row_nxt = row_r;
    if (ctrl.wr_en && (ctrl.wr_src == cell_idx)) begin
      row_nxt[ctrl.wr_dst] = 1'b1;
    end
  end

  always_comb begin
    vis_nxt = vis_r;
    if (ctrl.clear_vis) begin
      vis_nxt = 1'b0;
    end else if (ctrl.set_root && (ctrl.root == cell_idx)) begin
      vis_nxt = 1'b1;
    end else if (ctrl.expand && reach_in[cell_idx]) begin
      vis_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      vis_r <= 1'b0;
    end else begin
      row_r <= row_nxt;
      vis_r <= vis_nxt;
    end
  end

  // A visited node adds its in-use successors to the mask passed down the row.
  assign acc_out = acc_in | (vis_r ? (row_r & in_use) : '0);
  assign row     = row_r;
  assign vis     = vis_r;

endmodule

// File: rtl/core/adjacency_graph_component_counter.sv
// Graph component counter over a 16-node directed adjacency bit matrix.
// in_tdata carries a command: add edge, query edge or count walk roots.
// Every input beat yields exactly one out_tdata beat. ok is 1 for a stored
// edge, a present edge, or a finished count; root_count is nonzero only
// for a count. cfg_data sets the number of nodes in use; write it only while the
// block is idle, the block itself does not enforce it; values above 16 act as 16.
// Add, query and the unused command give their result in the cycle after the
// input beat. A count sweeps candidate roots one per cycle, pausing while a root
// is expanded; for each new root it grows the visited set once per cycle through
// the row of node cells until it stops changing. One command is in flight at a time.
// The result sits in an output register; the next input beat is taken while
// that result is being accepted. If the receiver stalls, in_tready stays low
// until the result register is free.
// Reset clears the matrix and visited marks and sets the node count to 16.
module adjacency_graph_component_counter (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [15:0] in_tdata,   // [1:0] cmd, [5:2] source_node, [9:6] target_node
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [0] ok, [5:1] root_count
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [4:0] cfg_data     // [4:0] node_count
);

  localparam int N = agcc_pkg::MAX_NODES;
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_EXPAND = 2'd2;
  localparam logic [1:0] ST_DONE   = 2'd3;

  logic [1:0]                     st_r, st_nxt;
  logic [agcc_pkg::CNT_W-1:0]     node_count_r, node_count_nxt;
  logic [agcc_pkg::CNT_W-1:0]     r_r, r_nxt;
  logic [agcc_pkg::CNT_W-1:0]     roots_r, roots_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic                           out_ok_r, out_ok_nxt;
  logic [agcc_pkg::CNT_W-1:0]     out_roots_r, out_roots_nxt;

  logic [agcc_pkg::CMD_W-1:0]     cmd;
  agcc_pkg::node_idx_t            src, dst;
  logic [agcc_pkg::CNT_W-1:0]     n_act;
  agcc_pkg::node_mask_t           in_use;
  agcc_pkg::node_mask_t           acc [N+1];
  agcc_pkg::node_mask_t           rows [N];
  agcc_pkg::node_mask_t           vis_vec;
  agcc_pkg::node_mask_t           reach;
  agcc_pkg::cell_ctrl_t           ctrl;
  logic                           accept, slot_free, in_range, present;

  assign cmd = in_tdata[1:0];
  assign src = in_tdata[5:2];
  assign dst = in_tdata[9:6];

  assign n_act = (node_count_r > agcc_pkg::CNT_W'(N)) ? agcc_pkg::CNT_W'(N) : node_count_r;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      in_use[i] = (agcc_pkg::CNT_W'(i) < n_act);
    end
  end

  assign acc[0] = '0;

  for (genvar g = 0; g < N; g++) begin : g_cell
    agcc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (agcc_pkg::IDX_W'(g)),
      .ctrl     (ctrl),
      .in_use   (in_use),
      .reach_in (reach),
      .acc_in   (acc[g]),
      .acc_out  (acc[g+1]),
      .row      (rows[g]),
      .vis      (vis_vec[g])
    );
  end

  assign reach = acc[N];

  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (st_r == ST_IDLE) && slot_free;
  assign accept    = in_tvalid && in_tready;
  assign in_range  = ({1'b0, src} < n_act) && ({1'b0, dst} < n_act);
  assign present   = rows[src][dst];
  assign cfg_ready = 1'b1;

  always_comb begin
    st_r_hold:
    begin
      st_nxt        = st_r;
      r_nxt         = r_r;
      roots_nxt     = roots_r;
      out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
      out_ok_nxt    = out_ok_r;
      out_roots_nxt = out_roots_r;
      node_count_nxt = cfg_valid ? cfg_data : node_count_r;
      ctrl          = '0;
      ctrl.wr_src   = src;
      ctrl.wr_dst   = dst;
      ctrl.root     = r_r[agcc_pkg::IDX_W-1:0];
    end
    case (st_r)
      ST_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          out_roots_nxt = '0;
          case (cmd)
            agcc_pkg::CMD_ADD: begin
              out_ok_nxt = in_range && !present && (src != dst);
              ctrl.wr_en = in_range && !present && (src != dst);
            end
            agcc_pkg::CMD_QUERY: begin
              out_ok_nxt = in_range && present;
            end
            agcc_pkg::CMD_COUNT: begin
              out_valid_nxt  = 1'b0;
              ctrl.clear_vis = 1'b1;
              r_nxt          = '0;
              roots_nxt      = '0;
              st_nxt         = ST_SCAN;
            end
            default: begin
              out_ok_nxt = 1'b0;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (r_r >= n_act) begin
          st_nxt = ST_DONE;
        end else if (!vis_vec[r_r[agcc_pkg::IDX_W-1:0]]) begin
          ctrl.set_root = 1'b1;
          roots_nxt     = roots_r + 1'b1;
          st_nxt        = ST_EXPAND;
        end else begin
          r_nxt = r_r + 1'b1;
        end
      end
      ST_EXPAND: begin
        // Grow the visited set until a pass through the cells adds nothing.
        ctrl.expand = 1'b1;
        if ((reach & ~vis_vec) == '0) begin
          r_nxt  = r_r + 1'b1;
          st_nxt = ST_SCAN;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = 1'b1;
          out_roots_nxt = roots_r;
          st_nxt        = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      node_count_r <= agcc_pkg::CNT_W'(N);
      out_valid_r  <= 1'b0;
      r_r          <= '0;
      roots_r      <= '0;
    end else begin
      st_r         <= st_nxt;
      node_count_r <= node_count_nxt;
      out_valid_r  <= out_valid_nxt;
      r_r          <= r_nxt;
      roots_r      <= roots_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_ok_r    <= out_ok_nxt;
    out_roots_r <= out_roots_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_roots_r, out_ok_r};

endmodule
